### rtl/cdmsf_pkg.sv
// ----------------------------------------------------------------------------
// cdmsf_pkg
// types and constants shared by the cd sector msf address unit
// ----------------------------------------------------------------------------
package cdmsf_pkg;

    // transaction kinds
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

    // input transaction
    typedef struct packed {
        t_mode       mode;
        logic [18:0] lba;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [7:0] minute_bcd;
        logic [6:0] second_bcd;
        logic [6:0] frame_bcd;
        logic       overflow;
    } t_out_item;

    // load split into binary minute, second and frame
    typedef struct packed {
        t_mode      mode;
        logic       overflow;
        logic [6:0] minute;
        logic [5:0] second;
        logic [6:0] frame;
    } t_split_item;

    localparam logic [19:0] LEAD_IN_SECTORS = 20'd150;
    localparam logic [18:0] MAX_BLOCK       = 19'd449999;
    localparam logic [12:0] SECTORS_PER_MIN = 13'd4500;
    localparam logic [6:0]  FRAMES_PER_SEC  = 7'd75;

    // floor(x / 4500) = (x * MIN_RECIP) >> MIN_SHIFT, exact for x <= 449999
    localparam logic [18:0] MIN_RECIP = 19'd477219;
    localparam int          MIN_SHIFT = 31;
    // floor(x / 75) = (x * SEC_RECIP) >> SEC_SHIFT, exact for x < 4500
    localparam logic [9:0]  SEC_RECIP = 10'd874;
    localparam int          SEC_SHIFT = 16;

    // last bcd values before each field wraps
    localparam logic [7:0] FRAME_LAST_BCD  = 8'h74;
    localparam logic [7:0] SECOND_LAST_BCD = 8'h59;
    localparam logic [7:0] MINUTE_LAST_BCD = 8'h99;

    // address after reset, 00:02:16
    localparam logic [7:0] MINUTE_RST_BCD = 8'h00;
    localparam logic [6:0] SECOND_RST_BCD = 7'h02;
    localparam logic [6:0] FRAME_RST_BCD  = 7'h16;

endpackage

### rtl/cd_sector_msf_address_unit_core.sv
// ----------------------------------------------------------------------------
// cd_sector_msf_address_unit_core
// cd sector address register in bcd minute:second:frame, loaded from a
// logical block number or stepped by one sector
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//
//  one result transaction per input transaction, in order
//  the path from acceptance to o_out_valid runs through five split stages
//  (clamp, minute reciprocal, minute remainder, second reciprocal, frame
//  remainder) and the address register, which is also the result register
//  one transaction per cycle sustained while i_out_ready is high; each stage holds while stalled and
//  refills as soon as it empties, so input keeps flowing into empty stages
//  while a result waits
//  synchronous active-low reset empties the pipeline and sets the address
//  to 00:02:16
//
module cd_sector_msf_address_unit_core import cdmsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // split pipeline to address register
    logic        split_valid;
    logic        split_ready;
    t_split_item split_item;

    // block number -> binary minute / second / frame
    // steps pass through so they stay in order behind earlier loads
    cdmsf_lba_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_valid (split_valid),
        .i_ready (split_ready),
        .o_item  (split_item)
    );

    // the address is only read at the end of the pipe, so a step sees
    // every earlier load already applied
    cdmsf_addr_reg u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (split_ready),
        .i_item  (split_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

### rtl/cdmsf_lba_split.sv
// ----------------------------------------------------------------------------
// cdmsf_lba_split
// five-stage pipeline that turns a block number into binary minute,
// second and frame; step transactions ride along untouched
// ----------------------------------------------------------------------------
module cdmsf_lba_split import cdmsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_split_item o_item
);

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    t_mode       r_mode1, r_mode2, r_mode3, r_mode4, r_mode5;
    logic        r_ovf1, r_ovf2, r_ovf3, r_ovf4, r_ovf5;
    logic [18:0] r_blk1, r_blk2;
    logic [6:0]  r_min2, r_min3, r_min4, r_min5;
    logic [12:0] r_rem3, r_rem4;
    logic [5:0]  r_sec4, r_sec5;
    logic [6:0]  r_frm5;

    logic        s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
    logic [19:0] w_sum;
    logic        w_ovf;
    logic [37:0] w_mprod;
    logic [19:0] w_mbase;
    logic [19:0] w_rem;
    logic [22:0] w_sprod;
    logic [12:0] w_sbase;
    logic [12:0] w_frm;

    // a stage takes new data when empty or when its content moves on
    assign s5_rdy  = !r_v5 || i_ready;
    assign s4_rdy  = !r_v4 || s5_rdy;
    assign s3_rdy  = !r_v3 || s4_rdy;
    assign s2_rdy  = !r_v2 || s3_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_ready = s1_rdy;

    // lead-in offset and clamp
    assign w_sum = {1'b0, i_item.lba} + LEAD_IN_SECTORS;
    assign w_ovf = (i_item.mode == MODE_LOAD) && (w_sum > {1'b0, MAX_BLOCK});

    // minutes by reciprocal
    assign w_mprod = {19'd0, r_blk1} * {19'd0, MIN_RECIP};

    // sectors left inside the minute
    assign w_mbase = {13'd0, r_min2} * {7'd0, SECTORS_PER_MIN};
    assign w_rem   = {1'b0, r_blk2} - w_mbase;

    // seconds by reciprocal
    assign w_sprod = {10'd0, r_rem3} * {13'd0, SEC_RECIP};

    // frames left inside the second
    assign w_sbase = {7'd0, r_sec4} * {6'd0, FRAMES_PER_SEC};
    assign w_frm   = r_rem4 - w_sbase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s1_rdy) r_v1 <= i_valid;
            if (s2_rdy) r_v2 <= r_v1;
            if (s3_rdy) r_v3 <= r_v2;
            if (s4_rdy) r_v4 <= r_v3;
            if (s5_rdy) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_mode1 <= i_item.mode;
            r_ovf1  <= w_ovf;
            r_blk1  <= w_ovf ? MAX_BLOCK : w_sum[18:0];
        end
        if (s2_rdy) begin
            r_mode2 <= r_mode1;
            r_ovf2  <= r_ovf1;
            r_blk2  <= r_blk1;
            r_min2  <= w_mprod[MIN_SHIFT+6:MIN_SHIFT];
        end
        if (s3_rdy) begin
            r_mode3 <= r_mode2;
            r_ovf3  <= r_ovf2;
            r_min3  <= r_min2;
            r_rem3  <= w_rem[12:0];
        end
        if (s4_rdy) begin
            r_mode4 <= r_mode3;
            r_ovf4  <= r_ovf3;
            r_min4  <= r_min3;
            r_rem4  <= r_rem3;
            r_sec4  <= w_sprod[SEC_SHIFT+5:SEC_SHIFT];
        end
        if (s5_rdy) begin
            r_mode5 <= r_mode4;
            r_ovf5  <= r_ovf4;
            r_min5  <= r_min4;
            r_sec5  <= r_sec4;
            r_frm5  <= w_frm[6:0];
        end
    end

    assign o_valid         = r_v5;
    assign o_item.mode     = r_mode5;
    assign o_item.overflow = r_ovf5;
    assign o_item.minute   = r_min5;
    assign o_item.second   = r_sec5;
    assign o_item.frame    = r_frm5;

endmodule

### rtl/cdmsf_addr_reg.sv
// ----------------------------------------------------------------------------
// cdmsf_addr_reg
// current bcd address: loaded from a split transaction or stepped by one
// sector, and presented as the result register
// ----------------------------------------------------------------------------
module cdmsf_addr_reg import cdmsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_split_item i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);

    // shift-add-3 conversion, seven steps
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [7:0] bcd;
        bcd = 8'd0;
        for (int i = 6; i >= 0; i--) begin
            if (bcd[3:0] >= 4'd5) bcd[3:0] = bcd[3:0] + 4'd3;
            if (bcd[7:4] >= 4'd5) bcd[7:4] = bcd[7:4] + 4'd3;
            bcd = {bcd[6:0], v[i]};
        end
        return bcd;
    endfunction

    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [7:0] res;
        if (v[3:0] == 4'd9) begin
            res = {v[7:4] + 4'd1, 4'd0};
        end else begin
            res = {v[7:4], v[3:0] + 4'd1};
        end
        return res;
    endfunction

    logic       r_valid;
    logic [7:0] r_min;
    logic [6:0] r_sec;
    logic [6:0] r_frm;
    logic       r_ovf;

    logic       w_fire;
    logic [7:0] w_frm_ext, w_sec_ext;
    logic [7:0] n_min, n_sec, n_frm;
    logic [7:0] w_ld_min, w_ld_sec, w_ld_frm;

    assign o_ready = !r_valid || i_ready;
    assign w_fire  = i_valid && o_ready;

    assign w_frm_ext = {1'b0, r_frm};
    assign w_sec_ext = {1'b0, r_sec};

    assign w_ld_min = bin_to_bcd(i_item.minute);
    assign w_ld_sec = bin_to_bcd({1'b0, i_item.second});
    assign w_ld_frm = bin_to_bcd(i_item.frame);

    always_comb begin
        n_min = r_min;
        n_sec = w_sec_ext;
        n_frm = w_frm_ext;
        case (i_item.mode)
            MODE_LOAD: begin
                n_min = w_ld_min;
                n_sec = w_ld_sec;
                n_frm = w_ld_frm;
            end
            default: begin
                // ripple frame -> second -> minute
                if (w_frm_ext == FRAME_LAST_BCD) begin
                    n_frm = 8'h00;
                    if (w_sec_ext == SECOND_LAST_BCD) begin
                        n_sec = 8'h00;
                        n_min = (r_min == MINUTE_LAST_BCD) ? 8'h00 : bcd_inc(r_min);
                    end else begin
                        n_sec = bcd_inc(w_sec_ext);
                    end
                end else begin
                    n_frm = bcd_inc(w_frm_ext);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_min   <= MINUTE_RST_BCD;
            r_sec   <= SECOND_RST_BCD;
            r_frm   <= FRAME_RST_BCD;
        end else begin
            if (o_ready) r_valid <= i_valid;
            if (w_fire) begin
                r_min <= n_min;
                r_sec <= n_sec[6:0];
                r_frm <= n_frm[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_ovf <= (i_item.mode == MODE_LOAD) && i_item.overflow;
    end

    assign o_valid           = r_valid;
    assign o_item.minute_bcd = r_min;
    assign o_item.second_bcd = r_sec;
    assign o_item.frame_bcd  = r_frm;
    assign o_item.overflow   = r_ovf;

endmodule
